// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file of the classifier.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define LTC_ASSERT_CR(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, on the house clock and reset names clk_i and rst_ni.
`define LTC_ASSERT(label, prop, msg) \
  `LTC_ASSERT_CR(label, clk_i, rst_ni, prop, msg)

`endif

// ----- src/ltc_pkg.sv -----
// Types, character constants and helper functions of the literal token classifier.
// Depends on nothing; used by the top level, its checker and the testbench.
package ltc_pkg;

  typedef enum logic [3:0] {
    CLS_EMPTY   = 4'd0,
    CLS_STRING  = 4'd1,
    CLS_BOOL    = 4'd2,
    CLS_STRUCT  = 4'd3,
    CLS_INT     = 4'd4,
    CLS_FLOAT   = 4'd5,
    CLS_DOUBLE  = 4'd6,
    CLS_IDENT   = 4'd7,
    CLS_INVALID = 4'd8
  } class_e;

  localparam logic [2:0] CountMax = 3'd6;
  localparam logic [2:0] TrueLen  = 3'd4;
  localparam logic [2:0] FalseLen = 3'd5;

  localparam logic [7:0] ChQuote = 8'h22;  // "
  localparam logic [7:0] ChBrace = 8'h7B;  // {
  localparam logic [7:0] ChMinus = 8'h2D;  // -
  localparam logic [7:0] ChDot   = 8'h2E;  // .
  localparam logic [7:0] ChLowF  = 8'h66;  // f
  localparam logic [7:0] ChUpF   = 8'h46;  // F
  localparam logic [7:0] ChUnder = 8'h5F;  // _

  // Per-token scan state.
  typedef struct packed {
    logic [2:0] count;
    logic [7:0] first;
    logic [7:0] last;
    logic       seen_dot;
    logic       number_ok;
    logic       name_ok;
    logic       true_match;
    logic       false_match;
  } tok_t;

  localparam tok_t TokReset = '{
    count:       3'd0,
    first:       8'h00,
    last:        8'h00,
    seen_dot:    1'b0,
    number_ok:   1'b1,
    name_ok:     1'b1,
    true_match:  1'b1,
    false_match: 1'b1
  };

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_f(input logic [7:0] c);
    return (c == ChLowF) || (c == ChUpF);
  endfunction

  // Characters of the word "true" by position.
  function automatic logic [7:0] true_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h74;  // t
      3'd1:    ch = 8'h72;  // r
      3'd2:    ch = 8'h75;  // u
      3'd3:    ch = 8'h65;  // e
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Characters of the word "false" by position.
  function automatic logic [7:0] false_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h66;  // f
      3'd1:    ch = 8'h61;  // a
      3'd2:    ch = 8'h6C;  // l
      3'd3:    ch = 8'h73;  // s
      3'd4:    ch = 8'h65;  // e
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ----- src/literal_token_classifier_unit.sv -----
// Top level of the literal token classifier: input register, token scan, result register.
// Depends on ltc_pkg.
//
// Feed the characters of a token one transaction per cycle; mark the last one with
// end_of_token_i. The block sustains one character per cycle with no bubbles between
// tokens. A class code appears on the output after the end-marked transaction is
// accepted: the input register holds it, and the scan logic feeds the result register
// when it is free. The input side stalls only when a finished result is still waiting in the
// result register and the next end-marked transaction needs that slot; plain characters
// keep flowing. Classes in order of precedence: quoted string of two or more characters,
// exact true or false (bool), brace-led struct, number (optional leading minus, at most
// one dot; a trailing f or F after a dot is float, other dotted numbers are double, no
// dot is int, a lone minus is int, a lone dot is double), identifier, else invalid. An
// end mark with no characters taken gives the empty code. Tokens of any length are
// classified; the character count saturates at six, which covers every length test.
module literal_token_classifier_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          token_char_i,
  input  logic                char_present_i,
  input  logic                end_of_token_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ltc_pkg::class_e     literal_class_o
);
  import ltc_pkg::*;

  // Input register.
  logic       in_valid_q;
  logic [7:0] char_q;
  logic       present_q;
  logic       end_q;

  // Token scan state and result register.
  tok_t   tok_q, tok_d, tok_nx;
  logic   out_valid_q;
  class_e class_q, class_d;

  logic advance;

  // Advance the held transaction unless it ends a token and the result slot is
  // still occupied by a stalled result.
  assign advance    = in_valid_q && (!end_q || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  // Fold the held character into the token state.
  always_comb begin
    logic [2:0] pos;
    logic [7:0] c;
    pos    = tok_q.count;
    c      = char_q;
    tok_nx = tok_q;
    if (present_q) begin
      if (pos == 3'd0) begin
        tok_nx.first = c;
      end

      if ((pos >= TrueLen) || (c != true_char(pos))) begin
        tok_nx.true_match = 1'b0;
      end
      if ((pos >= FalseLen) || (c != false_char(pos))) begin
        tok_nx.false_match = 1'b0;
      end

      // A leading minus is skipped by the number scan.
      if (!((pos == 3'd0) && (c == ChMinus))) begin
        // An f or F may only be the last character of a number.
        if ((pos != 3'd0) && is_f(tok_q.last)) begin
          tok_nx.number_ok = 1'b0;
        end
        if (c == ChDot) begin
          if (tok_q.seen_dot) begin
            tok_nx.number_ok = 1'b0;
          end else begin
            tok_nx.seen_dot = 1'b1;
          end
        end else if (!is_digit(c) && !(is_f(c) && tok_q.seen_dot)) begin
          tok_nx.number_ok = 1'b0;
        end
      end

      if (pos == 3'd0) begin
        tok_nx.name_ok = is_alpha(c) || (c == ChUnder);
      end else if (!(is_alpha(c) || is_digit(c) || (c == ChUnder))) begin
        tok_nx.name_ok = 1'b0;
      end

      tok_nx.last = c;
      if (tok_q.count < CountMax) begin
        tok_nx.count = tok_q.count + 3'd1;
      end
    end
  end

  // Classify the updated token by precedence.
  always_comb begin
    priority if (tok_nx.count == 3'd0) begin
      class_d = CLS_EMPTY;
    end else if ((tok_nx.count >= 3'd2) && (tok_nx.first == ChQuote) &&
                 (tok_nx.last == ChQuote)) begin
      class_d = CLS_STRING;
    end else if ((tok_nx.true_match && (tok_nx.count == TrueLen)) ||
                 (tok_nx.false_match && (tok_nx.count == FalseLen))) begin
      class_d = CLS_BOOL;
    end else if (tok_nx.first == ChBrace) begin
      class_d = CLS_STRUCT;
    end else if (tok_nx.number_ok) begin
      if (!tok_nx.seen_dot) begin
        class_d = CLS_INT;
      end else if (is_f(tok_nx.last)) begin
        class_d = CLS_FLOAT;
      end else begin
        class_d = CLS_DOUBLE;
      end
    end else if (tok_nx.name_ok) begin
      class_d = CLS_IDENT;
    end else begin
      class_d = CLS_INVALID;
    end
  end

  // Drop the scan state back to reset after each token end.
  always_comb begin
    tok_d = tok_q;
    if (advance) begin
      tok_d = end_q ? TokReset : tok_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      tok_q       <= TokReset;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      tok_q <= tok_d;
      if (advance && end_q) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: hold while stalled.
  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      char_q    <= token_char_i;
      present_q <= char_present_i;
      end_q     <= end_of_token_i;
    end
    if (advance && end_q) begin
      class_q <= class_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign literal_class_o = class_q;

endmodule

// ----- src/ltc_checker.sv -----
// Port-level checker for the literal token classifier, bound to the top level.
// Depends on ltc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ltc_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input logic            end_of_token_i,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input ltc_pkg::class_e literal_class_o
);
  import ltc_pkg::*;

  logic end_acc;
  logic out_block;
  assign end_acc   = in_valid_i && !in_stall_o && end_of_token_i;
  assign out_block = out_valid_o && out_stall_i;

  `LTC_ASSERT(a_class_range, out_valid_o |-> (literal_class_o <= CLS_INVALID), "bad class")
  `LTC_ASSERT(a_stall_cause, in_stall_o |-> out_block, "input stalled without a blocked result")
  `LTC_ASSERT(a_result_latency, $rose(out_valid_o) |-> $past(end_acc, 2), "result without end")
  `LTC_ASSERT(a_out_hold, out_block |=> (out_valid_o && $stable(literal_class_o)), "result changed")

endmodule

bind literal_token_classifier_unit ltc_checker u_ltc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .end_of_token_i  (end_of_token_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .literal_class_o (literal_class_o)
);

// ----- verif/tb_literal_token_classifier_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of literal_token_classifier_unit: directed and random tokens.
// Keeps its own class predictor and checks every result in order. Depends on ltc_pkg.
module tb_literal_token_classifier_unit;
  import ltc_pkg::*;

  localparam int HoldLen     = 400;   // receiver hold-off used to fill the block
  localparam int WatchLimit  = 4000;  // cycles without any transaction before giving up
  localparam int DrainCycles = 10;    // margin after the last pending result

  typedef logic [7:0] char_q_t[$];

  // Scan state of the token in flight, as the predictor sees it.
  typedef struct packed {
    logic [2:0] count;
    logic [7:0] first_ch;
    logic [7:0] last_ch;
    logic       dot_seen;
    logic       number_ok;
    logic       name_ok;
    logic       true_ok;
    logic       false_ok;
  } scan_t;

  localparam scan_t ScanClear = '{
    count:     3'd0,
    first_ch:  8'h00,
    last_ch:   8'h00,
    dot_seen:  1'b0,
    number_ok: 1'b1,
    name_ok:   1'b1,
    true_ok:   1'b1,
    false_ok:  1'b1
  };

  localparam logic [31:0] TrueWord  = "true";
  localparam logic [39:0] FalseWord = "false";

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       in_stall_o;
  logic [7:0] token_char_i   = 8'h00;
  logic       char_present_i = 1'b0;
  logic       end_of_token_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i    = 1'b0;
  class_e     literal_class_o;

  scan_t       scan;
  class_e      pending_classes[$];
  int unsigned class_hits[9];
  int unsigned items_sent, chars_sent, ignored_sent, tokens_sent, results_seen;
  int unsigned error_count;
  bit          tx_idle_on, rx_idle_on;
  int          hold_req, hold_seen, hold_left;
  int          quiet_cycles;

  literal_token_classifier_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .token_char_i    (token_char_i),
    .char_present_i  (char_present_i),
    .end_of_token_i  (end_of_token_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .literal_class_o (literal_class_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Class predictor
  // ---------------------------------------------------------------------------
  function automatic logic digit_ch(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic letter_ch(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic eff_ch(input logic [7:0] c);
    return c == ChLowF || c == ChUpF;
  endfunction

  // Fold one character into the scan state.
  function automatic void scan_char(input logic [7:0] c);
    int pi;
    pi = int'(scan.count);
    if (pi == 0) scan.first_ch = c;

    // Keyword tracking: still a prefix of the word at this position.
    if (pi < int'(TrueLen)) begin
      if (c != TrueWord[8*(3 - pi) +: 8]) scan.true_ok = 1'b0;
    end else begin
      scan.true_ok = 1'b0;
    end
    if (pi < int'(FalseLen)) begin
      if (c != FalseWord[8*(4 - pi) +: 8]) scan.false_ok = 1'b0;
    end else begin
      scan.false_ok = 1'b0;
    end

    // Numeric scan; a leading minus is skipped, an f after a dot must be last.
    if (!(pi == 0 && c == ChMinus)) begin
      if (pi != 0 && eff_ch(scan.last_ch)) scan.number_ok = 1'b0;
      if (c == ChDot) begin
        if (scan.dot_seen) scan.number_ok = 1'b0;
        else scan.dot_seen = 1'b1;
      end else if (!digit_ch(c) && !(eff_ch(c) && scan.dot_seen)) begin
        scan.number_ok = 1'b0;
      end
    end

    if (pi == 0) scan.name_ok = letter_ch(c) || c == ChUnder;
    else if (!(letter_ch(c) || digit_ch(c) || c == ChUnder)) scan.name_ok = 1'b0;

    scan.last_ch = c;
    if (scan.count < CountMax) scan.count = scan.count + 3'd1;
  endfunction

  // Class of the token scanned so far, by precedence.
  function automatic class_e token_class();
    if (scan.count == 3'd0) return CLS_EMPTY;
    if (scan.count >= 3'd2 && scan.first_ch == ChQuote && scan.last_ch == ChQuote)
      return CLS_STRING;
    if ((scan.true_ok && scan.count == TrueLen) || (scan.false_ok && scan.count == FalseLen))
      return CLS_BOOL;
    if (scan.first_ch == ChBrace) return CLS_STRUCT;
    if (scan.number_ok) begin
      if (!scan.dot_seen) return CLS_INT;
      return eff_ch(scan.last_ch) ? CLS_FLOAT : CLS_DOUBLE;
    end
    if (scan.name_ok) return CLS_IDENT;
    return CLS_INVALID;
  endfunction

  // Apply one accepted transaction; queue the class when it ends a token.
  function automatic void predict_item(input logic [7:0] c, input logic present,
                                       input logic last);
    if (present) scan_char(c);
    if (last) begin
      pending_classes.push_back(token_class());
      scan = ScanClear;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // Enter and leave at a falling edge; hold the payload until accepted.
  task automatic send_item(input logic [7:0] c, input logic present, input logic last);
    while (tx_idle_on && $urandom_range(0, 99) < 16) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    token_char_i   <= c;
    char_present_i <= present;
    end_of_token_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    predict_item(c, present, last);
    if (present || last) items_sent++;
    else ignored_sent++;
    if (present) chars_sent++;
    if (last) tokens_sent++;
    @(negedge clk_i);
  endtask

  // Send a whole token; optionally end it with a bare end mark and sprinkle
  // transactions that carry neither a character nor an end.
  task automatic send_token(input char_q_t q, input bit split_end, input bit noisy);
    if (q.size() == 0) begin
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end else begin
      foreach (q[i]) begin
        if (noisy && $urandom_range(0, 3) == 0)
          send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        send_item(q[i], 1'b1, (i == q.size() - 1) && !split_end);
      end
      if (split_end) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  function automatic char_q_t text_chars(input string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'h30 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_name_char(input bit allow_digit);
    int r;
    r = $urandom_range(0, allow_digit ? 62 : 52);
    if (r < 26) return 8'h61 + 8'(r);
    if (r < 52) return 8'h41 + 8'(r - 26);
    if (r == 52) return ChUnder;
    return 8'h30 + 8'(r - 53);
  endfunction

  // Mostly well-formed tokens of every class with random content, plus
  // near misses and raw noise.
  function automatic char_q_t random_token();
    char_q_t q;
    int      n;
    int      bad;
    case ($urandom_range(0, 9))
      0: begin  // integer
        if ($urandom_range(0, 2) == 0) q.push_back(ChMinus);
        repeat ($urandom_range(1, 5)) q.push_back(rand_digit());
      end
      1: begin  // dotted number, float or double
        if ($urandom_range(0, 2) == 0) q.push_back(ChMinus);
        repeat ($urandom_range(0, 3)) q.push_back(rand_digit());
        q.push_back(ChDot);
        repeat ($urandom_range(0, 3)) q.push_back(rand_digit());
        case ($urandom_range(0, 2))
          0: q.push_back(ChLowF);
          1: q.push_back(ChUpF);
          default: ;
        endcase
      end
      2: begin  // identifier
        q.push_back(rand_name_char(1'b0));
        repeat ($urandom_range(0, 6)) q.push_back(rand_name_char(1'b1));
      end
      3: begin  // keyword, exact or slightly off
        if ($urandom_range(0, 1) == 0) q = text_chars("true");
        else q = text_chars("false");
        case ($urandom_range(0, 3))
          1: void'(q.pop_back());
          2: q.push_back(rand_name_char(1'b1));
          3: q[$urandom_range(0, q.size() - 1)] = rand_name_char(1'b1);
          default: ;
        endcase
      end
      4: begin  // quoted, sometimes unterminated
        q.push_back(ChQuote);
        repeat ($urandom_range(0, 4)) q.push_back(8'($urandom_range(32, 126)));
        if ($urandom_range(0, 4) != 0) q.push_back(ChQuote);
      end
      5: begin  // brace-led
        q.push_back(ChBrace);
        repeat ($urandom_range(0, 4)) q.push_back(8'($urandom_range(0, 255)));
      end
      6: begin  // raw bytes
        repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(0, 255)));
      end
      7: begin  // number with one stray character
        n   = $urandom_range(2, 6);
        bad = $urandom_range(0, n - 1);
        for (int i = 0; i < n; i++) begin
          if (i != bad) q.push_back(rand_digit());
          else begin
            case ($urandom_range(0, 4))
              0: q.push_back(ChDot);
              1: q.push_back(ChMinus);
              2: q.push_back(ChLowF);
              3: q.push_back(ChUpF);
              default: q.push_back(8'($urandom_range(0, 255)));
            endcase
          end
        end
        if ($urandom_range(0, 1) == 0) q.push_back(ChDot);
      end
      8: q.push_back(8'($urandom_range(0, 255)));
      default: ;  // empty token
    endcase
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stall, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen   <= hold_req;
      hold_left   <= HoldLen;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= rx_idle_on && ($urandom_range(0, 99) < 16);
    end
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  // Compare each accepted result with the oldest pending class.
  always @(posedge clk_i) begin
    class_e want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_classes.size() == 0) begin
        report_mismatch($sformatf("result %0d with no token pending", literal_class_o));
      end else begin
        want = pending_classes.pop_front();
        class_hits[int'(want)]++;
        if (literal_class_o !== want)
          report_mismatch($sformatf("class %0d, expected %0d", literal_class_o, want));
      end
    end
  end

  // Give up when no transaction moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("no transaction for %0d cycles", WatchLimit);
      $display("literal_token_classifier_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // One token per precedence rule and edge case.
  task automatic test_directed_cases();
    char_q_t q;
    send_token(q, 1'b0, 1'b0);                     // end mark alone: empty
    send_token(text_chars("\"\""), 1'b0, 1'b0);    // shortest string
    send_token(text_chars("\"a b\""), 1'b0, 1'b0);
    send_token(text_chars("\""), 1'b0, 1'b0);      // lone quote is not a string
    send_token(text_chars("true"), 1'b0, 1'b0);
    send_token(text_chars("false"), 1'b0, 1'b0);
    send_token(text_chars("truex"), 1'b0, 1'b0);
    send_token(text_chars("fals"), 1'b0, 1'b0);
    send_token(text_chars("{}"), 1'b0, 1'b0);
    send_token(text_chars("-"), 1'b0, 1'b0);       // lone minus: int
    send_token(text_chars("."), 1'b0, 1'b0);       // lone dot: double
    send_token(text_chars("-42"), 1'b0, 1'b0);
    send_token(text_chars("3.14"), 1'b0, 1'b0);
    send_token(text_chars("2.5f"), 1'b0, 1'b0);
    send_token(text_chars(".F"), 1'b0, 1'b0);
    send_token(text_chars("1.5f0"), 1'b0, 1'b0);   // f not last
    send_token(text_chars("1.2.3"), 1'b0, 1'b0);
    send_token(text_chars("12f"), 1'b0, 1'b0);     // f without a dot
    send_token(text_chars("--1"), 1'b0, 1'b0);
    send_token(text_chars("_tmp9"), 1'b0, 1'b0);
    send_token(text_chars("very_long_name"), 1'b0, 1'b0);
    send_token(text_chars("1234567890"), 1'b0, 1'b0);
    q = '{8'h00};
    send_token(q, 1'b0, 1'b0);
    q = '{8'hFF};
    send_token(q, 1'b0, 1'b0);
    send_token(text_chars("42"), 1'b1, 1'b0);      // bare end mark after characters
    send_token(text_chars("ab"), 1'b0, 1'b1);      // empty transactions may come in between
  endtask

  task automatic test_random_tokens(input int unsigned n_items);
    int unsigned stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at)
      send_token(random_token(), $urandom_range(0, 4) == 0, $urandom_range(0, 5) == 0);
  endtask

  // Back-to-back traffic on both sides.
  task automatic test_steady_stream(input int unsigned n_items);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_tokens(n_items);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Hold the receiver off while short tokens keep coming, so the block fills
  // and stalls its input.
  task automatic test_result_backpressure();
    char_q_t q;
    tx_idle_on = 1'b0;
    hold_req++;
    repeat (40) begin
      q = '{rand_digit()};
      send_token(q, 1'b0, 1'b0);
    end
    tx_idle_on = 1'b1;
  endtask

  initial begin
    scan       = ScanClear;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_cases();
    test_random_tokens(1000);
    test_steady_stream(500);
    test_result_backpressure();
    test_random_tokens(350);

    in_valid_i <= 1'b0;
    while (pending_classes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d tokens: %0d characters, %0d empty transactions, %0d results",
             tokens_sent, chars_sent, ignored_sent, results_seen);
    $display("by class: empty %0d string %0d bool %0d struct %0d int %0d float %0d %s",
             class_hits[0], class_hits[1], class_hits[2], class_hits[3], class_hits[4],
             class_hits[5], $sformatf("double %0d ident %0d invalid %0d",
             class_hits[6], class_hits[7], class_hits[8]));
    if (error_count == 0) begin
      $display("literal_token_classifier_unit: match");
    end else begin
      $display("literal_token_classifier_unit: mismatch");
    end
    $finish;
  end

endmodule
